// ----- rtl/bst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block split table package
// Beat types, command and status codes and register indexes shared by the
// block split table modules.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam logic [1:0] CMD_SPLIT   = 2'd0;
    localparam logic [1:0] CMD_LENGTH  = 2'd1;
    localparam logic [1:0] CMD_LARGEST = 2'd2;
    localparam logic [1:0] CMD_BAD     = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [2:0] REG_DIM_COUNT = 3'd0;
    localparam logic [2:0] REG_EXTENT_0  = 3'd1;
    localparam logic [2:0] REG_EXTENT_1  = 3'd2;
    localparam logic [2:0] REG_EXTENT_2  = 3'd3;
    localparam logic [2:0] REG_EXTENT_3  = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  dimension;
        logic [15:0] position;
        logic [6:0]  block_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [6:0]  block_count;
    } out_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  dimension;
        logic [15:0] position;
        logic [6:0]  block_index;
    } task_t;

    typedef struct packed {
        logic  valid;
        task_t item;
    } queue_head_t;

endpackage

`default_nettype wire

// ----- rtl/block_split_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block split table
// Keeps sorted split points per tensor dimension and answers split, block
// length and largest block commands, one result beat per input beat.
// ----------------------------------------------------------------------------
// A two-entry input queue takes beats while the sequencer works, and a result
// register holds a finished beat while the next command runs. Commands run one
// at a time, and every stored point goes through the single read port of the
// point memory. A split scans the points of the addressed dimension in order
// and shifts the later ones up; a block length query reads at most two points;
// a largest block query walks the points of every dimension in use. No
// clearing pass follows reset: point counts start at zero and only counted
// points are read.
module block_split_table
    import bst_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_SPLITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        write_enable,
    input  wire logic [2:0]  register_index,
    input  wire logic [15:0] write_data
);

    queue_head_t q_head;
    logic        q_pop;

    bst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    bst_back #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_SPLITS (MAX_SPLITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/bst_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bst_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block split table front end
// Accepts input beats, classifies the command and holds the beats in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bst_front
    import bst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire in_t   in_data,
    input  wire logic  q_pop,
    output queue_head_t q_head
);

    task_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    task_t      item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        item.dimension   = in_data.dimension;
        item.position    = in_data.position;
        item.block_index = in_data.block_index;
        case (in_data.command)
            CMD_SPLIT:   item.op = CMD_SPLIT;
            CMD_LENGTH:  item.op = CMD_LENGTH;
            CMD_LARGEST: item.op = CMD_LARGEST;
            default:     item.op = CMD_BAD;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/bst_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block split table back end
// Sequencer that walks the stored split points through one memory port,
// keeps the configuration and point counts, and drives the result register.
// ----------------------------------------------------------------------------
module bst_back
    import bst_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_SPLITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire queue_head_t q_head,
    output logic             q_pop,
    input  wire logic        write_enable,
    input  wire logic [2:0]  register_index,
    input  wire logic [15:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data
);

    localparam int CW    = $clog2(MAX_SPLITS + 1);
    localparam int DEPTH = MAX_DIMS * MAX_SPLITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_INS_CHK  = 4'd3;
    localparam logic [3:0] S_SHIFT    = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_LEN_LO   = 4'd6;
    localparam logic [3:0] S_LEN_LO_W = 4'd7;
    localparam logic [3:0] S_LEN_HI   = 4'd8;
    localparam logic [3:0] S_LEN_HI_W = 4'd9;
    localparam logic [3:0] S_MAX_DIM  = 4'd10;
    localparam logic [3:0] S_MAX_RD   = 4'd11;
    localparam logic [3:0] S_MAX_CHK  = 4'd12;
    localparam logic [3:0] S_MUL_LO   = 4'd13;
    localparam logic [3:0] S_MUL_HI   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [2:0]    d_reg, d_next;
    logic [2:0]    k_reg, k_next;
    logic [15:0]   x_reg, x_next;
    logic [6:0]    idx_reg, idx_next;
    logic          dim_ok_reg, dim_ok_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [15:0]   lo_reg, lo_next;
    logic [15:0]   best_reg, best_next;
    logic [63:0]   prod_reg, prod_next;
    logic [47:0]   plo_reg, plo_next;
    logic [1:0]    status_reg, status_next;
    logic [63:0]   value_reg, value_next;
    logic [2:0]    dim_cnt_reg, dim_cnt_next;
    logic [15:0]   ext_reg [4];
    logic [15:0]   ext_next [4];
    logic [CW-1:0] cnt_reg [MAX_DIMS];
    logic [CW-1:0] cnt_next [MAX_DIMS];
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [47:0]   phi;
    logic [15:0]   len;
    logic [2:0]    q_dim;
    logic [2:0]    cfg_val;

    function automatic logic [AW-1:0] addr_of(input logic [2:0] dd, input logic [CW-1:0] ii);
        logic [31:0] a;
        a = 32'(dd) * MAX_SPLITS + 32'(ii);
        return AW'(a);
    endfunction

    function automatic logic [CW-1:0] cnt_of(input logic [2:0] dd);
        logic [CW-1:0] c;
        c = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (32'(dd) == k)
            begin
                c = cnt_reg[k];
            end
        end
        return c;
    endfunction

    function automatic logic dim_ok_of(input logic [2:0] dd, input logic [2:0] dc);
        return (dd < dc) && (32'(dd) < MAX_DIMS);
    endfunction

    function automatic logic [15:0] diff(input logic [15:0] hi, input logic [15:0] lo);
        return (hi >= lo) ? (hi - lo) : 16'd0;
    endfunction

    bst_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_points (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_dim = {1'b0, q_head.item.dimension};
    assign phi   = prod_reg[63:32] * best_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        dim_ok_next    = dim_ok_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        best_next      = best_reg;
        prod_next      = prod_reg;
        plo_next       = plo_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        dim_cnt_next   = dim_cnt_reg;
        ext_next       = ext_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = x_reg;
        len            = 16'd0;
        cfg_val        = write_data[2:0];

        if (write_enable)
        begin
            case (register_index)
                REG_DIM_COUNT:
                begin
                    if (cfg_val == 3'd0)
                    begin
                        cfg_val = 3'd1;
                    end
                    if (32'(cfg_val) > MAX_DIMS)
                    begin
                        cfg_val = 3'(MAX_DIMS);
                    end
                    dim_cnt_next = cfg_val;
                end
                REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3:
                begin
                    ext_next[2'(register_index - 3'd1)] = write_data;
                    for (int k = 0; k < MAX_DIMS; k++)
                    begin
                        if (32'(register_index) == k + 1)
                        begin
                            cnt_next[k] = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop       = 1'b1;
                    op_next     = q_head.item.op;
                    d_next      = q_dim;
                    x_next      = q_head.item.position;
                    idx_next    = q_head.item.block_index;
                    dim_ok_next = dim_ok_of(q_dim, dim_cnt_reg);
                    n_next      = cnt_of(q_dim);
                    status_next = ST_DONE;
                    value_next  = 64'd0;
                    i_next      = '0;
                    state_next  = S_DONE;
                    case (q_head.item.op)
                        CMD_SPLIT:
                        begin
                            if (!dim_ok_of(q_dim, dim_cnt_reg)
                                || q_head.item.position > ext_reg[q_dim[1:0]])
                            begin
                                status_next = ST_BAD;
                            end
                            else if (q_head.item.position == 16'd0
                                     || q_head.item.position == ext_reg[q_dim[1:0]])
                            begin
                                status_next = ST_PRESENT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LENGTH:
                        begin
                            if (!dim_ok_of(q_dim, dim_cnt_reg)
                                || 32'(q_head.item.block_index) > 32'(cnt_of(q_dim)))
                            begin
                                status_next = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_LEN_LO;
                            end
                        end
                        CMD_LARGEST:
                        begin
                            prod_next  = 64'd1;
                            k_next     = 3'd0;
                            state_next = S_MAX_DIM;
                        end
                        default:
                        begin
                            status_next = ST_BAD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(d_reg, i_reg);
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (rd_data == x_reg)
                begin
                    status_next = ST_PRESENT;
                    state_next  = S_DONE;
                end
                else if (rd_data > x_reg)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_INS_CHK:
            begin
                if (32'(n_reg) >= MAX_SPLITS)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    j_next     = n_reg;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (j_reg == i_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_of(d_reg, i_reg);
                    wr_data = x_reg;
                    for (int k = 0; k < MAX_DIMS; k++)
                    begin
                        if (32'(d_reg) == k)
                        begin
                            cnt_next[k] = n_reg + 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(d_reg, j_reg - 1'b1);
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = addr_of(d_reg, j_reg);
                wr_data    = rd_data;
                j_next     = j_reg - 1'b1;
                state_next = S_SHIFT;
            end
            S_LEN_LO:
            begin
                if (idx_reg == 7'd0)
                begin
                    lo_next    = 16'd0;
                    state_next = S_LEN_HI;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(d_reg, CW'(idx_reg - 7'd1));
                    state_next = S_LEN_LO_W;
                end
            end
            S_LEN_LO_W:
            begin
                lo_next    = rd_data;
                state_next = S_LEN_HI;
            end
            S_LEN_HI:
            begin
                if (32'(idx_reg) >= 32'(n_reg))
                begin
                    value_next = 64'(diff(ext_reg[d_reg[1:0]], lo_reg));
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(d_reg, CW'(idx_reg));
                    state_next = S_LEN_HI_W;
                end
            end
            S_LEN_HI_W:
            begin
                value_next = 64'(diff(rd_data, lo_reg));
                state_next = S_DONE;
            end
            S_MAX_DIM:
            begin
                if (k_reg >= dim_cnt_reg || 32'(k_reg) >= MAX_DIMS)
                begin
                    value_next = prod_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = cnt_of(k_reg);
                    j_next     = '0;
                    lo_next    = 16'd0;
                    best_next  = 16'd0;
                    state_next = S_MAX_RD;
                end
            end
            S_MAX_RD:
            begin
                if (j_reg == n_reg)
                begin
                    len        = diff(ext_reg[k_reg[1:0]], lo_reg);
                    best_next  = (len > best_reg) ? len : best_reg;
                    state_next = S_MUL_LO;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(k_reg, j_reg);
                    state_next = S_MAX_CHK;
                end
            end
            S_MAX_CHK:
            begin
                len        = diff(rd_data, lo_reg);
                best_next  = (len > best_reg) ? len : best_reg;
                lo_next    = rd_data;
                j_next     = j_reg + 1'b1;
                state_next = S_MAX_RD;
            end
            S_MUL_LO:
            begin
                plo_next   = prod_reg[31:0] * best_reg;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                prod_next  = 64'(plo_reg) + {phi[31:0], 32'd0};
                k_next     = k_reg + 3'd1;
                state_next = S_MAX_DIM;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.value        = value_reg;
                    out_data_next.block_count  = dim_ok_reg
                        ? 7'(32'(cnt_of(d_reg)) + 1) : 7'd1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            dim_cnt_reg   <= 3'd1;
            for (int k = 0; k < 4; k++)
            begin
                ext_reg[k] <= 16'd0;
            end
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dim_cnt_reg   <= dim_cnt_next;
            ext_reg       <= ext_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        d_reg        <= d_next;
        k_reg        <= k_next;
        x_reg        <= x_next;
        idx_reg      <= idx_next;
        dim_ok_reg   <= dim_ok_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        lo_reg       <= lo_next;
        best_reg     <= best_next;
        prod_reg     <= prod_next;
        plo_reg      <= plo_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/bst_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block split table checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module bst_chk
    import bst_pkg::*;
#(
    parameter int MAX_SPLITS = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result beat changed or dropped.");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_DONE |-> out_data.value == 64'd0)
        else $error("Failed command returned a nonzero value.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL
        |-> out_data.block_count == 7'(MAX_SPLITS + 1))
        else $error("Full status with a partly filled dimension.");

endmodule

bind block_split_table bst_chk #(
    .MAX_SPLITS (MAX_SPLITS)
) u_bst_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
